/* rtl/lcwf_pkg.sv */
// Shared types, constants and functions for the length/CRC/whitening framer.
// Holds the CRC-16 byte update, the whitening table and the result bundle type.
// No dependencies.
package lcwf_pkg;

    // Whitening table depth in use, and the longest payload that still fits it
    localparam int WHITEN_TABLE_DEPTH = 57;
    localparam int TABLE_SIZE         = 57;
    localparam logic [5:0] MAX_LEN    = 6'(WHITEN_TABLE_DEPTH - 3);

    // CRC-16, polynomial 0x8005, MSB first, no reflection
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h8005;

    localparam logic [7:0] WHITEN_TAB [TABLE_SIZE] = '{
        8'hff, 8'he1, 8'h1d, 8'h9a, 8'hed, 8'h85, 8'h33, 8'h24, 8'hea, 8'h7a,
        8'hd2, 8'h39, 8'h70, 8'h97, 8'h57, 8'h0a, 8'h54, 8'h7d, 8'h2d, 8'hd8,
        8'h6d, 8'h0d, 8'hba, 8'h8f, 8'h67, 8'h59, 8'hc7, 8'ha2, 8'hbf, 8'h34,
        8'hca, 8'h18, 8'h30, 8'h53, 8'h93, 8'hdf, 8'h92, 8'hec, 8'ha7, 8'h15,
        8'h8a, 8'hdc, 8'hf4, 8'h86, 8'h55, 8'h4e, 8'h18, 8'h21, 8'h40, 8'hc4,
        8'hc4, 8'hd5, 8'hc6, 8'h91, 8'h8a, 8'hcd, 8'he7
    };

    // Up to four frame bytes produced by one input word, in emit order
    typedef struct packed {
        logic [3:0][7:0] data;      // data[0] goes out first
        logic [1:0]      last_idx;  // index of the last valid byte
        logic            has_end;   // last byte closes the frame
    } lcwf_burst_t;

    // One byte through the CRC, eight shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] r;
        r = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (r[15]) begin
                r = (r << 1) ^ CRC_POLY;
            end else begin
                r = r << 1;
            end
        end
        return r;
    endfunction

    // Whitening byte for a frame position; zero beyond the table
    function automatic logic [7:0] whiten_at(input logic [5:0] pos);
        if (int'(pos) >= WHITEN_TABLE_DEPTH || int'(pos) >= TABLE_SIZE) begin
            return 8'h00;
        end
        return WHITEN_TAB[pos];
    endfunction

endpackage

/* rtl/length_crc_whiten_framer.sv */
// Top level of the length/CRC/whitening framer: stream ports and output burst buffer.
// Depends on lcwf_pkg and lcwf_builder.
// Output: the first byte of a word's burst is on m_tdata in the cycle after acceptance.
// Throughput: a word yields 1..4 bytes, one per output handshake; mid-frame words stream
// at one per cycle unless m_tready stalls; start/end words hold the input until drained.
// Reset: synchronous active-low aresetn empties the buffer and starts a new frame.
module length_crc_whiten_framer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] payload_byte, [13:8] frame_length, [15:14] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // frame_end
);
    import lcwf_pkg::*;

    lcwf_burst_t burst;
    lcwf_burst_t buf_reg;
    logic        buf_valid_reg;
    logic [1:0]  idx_reg;
    logic        s_accept;
    logic        m_take;
    logic        at_last;

    lcwf_builder u_builder (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (s_accept),
        .payload_byte (s_tdata[7:0]),
        .frame_length (s_tdata[13:8]),
        .burst        (burst)
    );

    // Output side: walk the buffered burst one byte at a time
    assign at_last  = idx_reg == buf_reg.last_idx;
    assign m_tvalid = buf_valid_reg;
    assign m_tdata  = buf_reg.data[idx_reg];
    assign m_tlast  = buf_reg.has_end && at_last;
    assign m_take   = buf_valid_reg && m_tready;

    // Input side: take a new word once the buffer empties or drains this cycle
    assign s_tready = !buf_valid_reg || (m_take && at_last);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (s_accept) begin
            buf_valid_reg <= 1'b1;
            idx_reg       <= 2'd0;
        end else if (m_take) begin
            if (at_last) begin
                buf_valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Burst payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            buf_reg <= burst;
        end
    end

    // An accepted word always shows output on the next cycle
    a_accept_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid && idx_reg == 2'd0)
        else $error("accepted word produced no output");

    // Read index never walks past the burst
    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> idx_reg <= buf_reg.last_idx)
        else $error("burst index past last byte");

    // Stalled output keeps its place in the burst
    a_idx_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(idx_reg) && m_tvalid)
        else $error("burst index moved under stall");

endmodule

/* rtl/lcwf_builder.sv */
// Frame state and per-word byte generation: length, payload, CRC, whitening.
// Depends on lcwf_pkg. Produces a burst of 1..4 bytes for every accepted word.
module lcwf_builder (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 accept,
    input  logic [7:0]           payload_byte,
    input  logic [5:0]           frame_length,
    output lcwf_pkg::lcwf_burst_t burst
);
    import lcwf_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [5:0]  pos_reg, pos_next;
    logic [5:0]  len_reg, len_next;

    logic        start;
    logic        done;
    logic [5:0]  req_len;
    logic [5:0]  len_use;
    logic [5:0]  pos_new;
    logic [15:0] crc_base;
    logic [15:0] crc_data;
    logic [7:0]  len_byte;
    logic [7:0]  data_byte;
    logic [7:0]  crc_hi;
    logic [7:0]  crc_lo;

    // Frame start detection and length clamp
    always_comb begin
        start   = (pos_reg == 6'd0) || (pos_reg >= len_reg);
        req_len = frame_length;
        if (req_len == 6'd0) begin
            req_len = 6'd1;
        end
        if (req_len > MAX_LEN) begin
            req_len = MAX_LEN;
        end
        len_use = start ? req_len : len_reg;
        pos_new = (start ? 6'd0 : pos_reg) + 6'd1;
        done    = pos_new >= len_use;
    end

    // CRC over the length byte (on frame start) then the payload byte
    always_comb begin
        crc_base = start ? crc_byte(CRC_INIT, {2'b00, req_len}) : crc_reg;
        crc_data = crc_byte(crc_base, payload_byte);
    end

    // Whitened bytes, packed in emit order
    always_comb begin
        len_byte  = {2'b00, len_use} ^ whiten_at(6'd0);
        data_byte = payload_byte ^ whiten_at(pos_new);
        crc_hi    = crc_data[15:8] ^ whiten_at(len_use + 6'd1);
        crc_lo    = crc_data[7:0] ^ whiten_at(len_use + 6'd2);

        burst.data[0]  = start ? len_byte : data_byte;
        burst.data[1]  = start ? data_byte : crc_hi;
        burst.data[2]  = start ? crc_hi : crc_lo;
        burst.data[3]  = crc_lo;
        burst.last_idx = {done, start};
        burst.has_end  = done;
    end

    // Next frame state
    always_comb begin
        crc_next = crc_reg;
        pos_next = pos_reg;
        len_next = len_reg;
        if (accept) begin
            len_next = len_use;
            if (done) begin
                crc_next = CRC_INIT;
                pos_next = 6'd0;
            end else begin
                crc_next = crc_data;
                pos_next = pos_new;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= CRC_INIT;
            pos_reg <= 6'd0;
            len_reg <= 6'd0;
        end else begin
            crc_reg <= crc_next;
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

    // Between frames the CRC sits at its seed
    a_crc_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg == 6'd0 |-> crc_reg == CRC_INIT)
        else $error("CRC not at seed between frames");

    // Mid-frame the position stays below the latched length
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg != 6'd0 |-> pos_reg < len_reg)
        else $error("payload position past frame length");

    // Latched length never exceeds the clamp
    a_len_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= MAX_LEN)
        else $error("latched length above table limit");

endmodule
